[design/ldsched_pkg.sv]
// shared constants, types and state encoding for the look disk scheduler
// no dependencies; used by every module of the block
package ldsched_pkg;

  localparam int MAX_REQUESTS = 32;
  localparam int TRACK_BITS   = 16;
  localparam int IDX_W        = $clog2(MAX_REQUESTS);
  localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
  localparam int SUM_W        = 22;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_EMIT
  } state_t;

  // operands for one compare of the shared scan unit
  typedef struct packed {
    logic                  cand_open;
    logic [TRACK_BITS-1:0] cand;
    logic [TRACK_BITS-1:0] head;
    logic                  up;
    logic                  best_valid;
    logic [TRACK_BITS-1:0] best_track;
  } cmp_in_t;

endpackage

[design/ldsched_store.sv]
// request store: one write port, one read port with registered read data
// depends on ldsched_pkg for depth and track width
module ldsched_store (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic [ldsched_pkg::IDX_W-1:0]      wr_addr,
  input  logic [ldsched_pkg::TRACK_BITS-1:0] wr_data,
  input  logic [ldsched_pkg::IDX_W-1:0]      rd_addr,
  output logic [ldsched_pkg::TRACK_BITS-1:0] rd_data
);

  logic [ldsched_pkg::TRACK_BITS-1:0] mem [ldsched_pkg::MAX_REQUESTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[design/ldsched_cmp.sv]
// shared compare unit: decides whether a candidate beats the current best
// depends on ldsched_pkg for cmp_in_t
module ldsched_cmp (
  input  ldsched_pkg::cmp_in_t op,
  output logic                 take
);

  logic in_dir;
  logic better;

  always_comb begin
    if (op.up) begin
      in_dir = (op.cand >= op.head);
      better = (op.cand < op.best_track);
    end else begin
      in_dir = (op.cand <= op.head);
      better = (op.cand > op.best_track);
    end
    // strict compare keeps the lowest index among equal tracks
    take = op.cand_open && in_dir && (!op.best_valid || better);
  end

endmodule

[design/look_disk_scheduler_core.sv]
// look disk scheduler top level: sequencer, head state and result register
// depends on ldsched_pkg, ldsched_store and ldsched_cmp
//
// usage: write start_head on the cfg channel while the block is idle. Stream
// requests in on s_axis, one word per cycle; tlast marks the final request of
// a batch. Up to MAX_REQUESTS are kept, further ones are dropped but a tlast
// still ends the batch. After tlast the block stops taking input and services
// the batch in look order, starting at start_head and sweeping upward first.
// Each result word on m_axis carries the track, the seek distance and the
// saturating running total; tlast marks the final result of the batch.
// timing: each result is chosen by a scan that reads one stored request per
// cycle through the single read port; a direction reversal adds one more
// scan. A stalled receiver holds the result register and the sequencer
// waits before loading the next result. Once the last result is loaded the
// block takes input again. Reset clears the batch, the served marks, the
// head (zero, sweeping up) and start_head; no clearing pass.
module look_disk_scheduler_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,       // start_head
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // request_track
  input  logic        s_axis_tlast,   // in_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // served_track, step_distance, total_distance, pad
  output logic        m_axis_tlast    // out_last
);

  localparam int TB = ldsched_pkg::TRACK_BITS;
  localparam int IW = ldsched_pkg::IDX_W;
  localparam int CW = ldsched_pkg::CNT_W;
  localparam int SW = ldsched_pkg::SUM_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(ldsched_pkg::MAX_REQUESTS);

  ldsched_pkg::state_t state, state_next;

  logic [TB-1:0]                         start_head;
  logic [CW-1:0]                         count;
  logic [CW-1:0]                         produced;
  logic [ldsched_pkg::MAX_REQUESTS-1:0]  served;
  logic [TB-1:0]                         head;
  logic                                  sweep_up;
  logic [SW-1:0]                         dist_sum;
  logic                                  flipped;
  logic [IW-1:0]                         scan_addr;
  logic                                  rd_valid;
  logic [IW-1:0]                         rd_idx;
  logic [TB-1:0]                         rd_data;
  logic                                  best_valid;
  logic [TB-1:0]                         best_track;
  logic [IW-1:0]                         best_idx;
  logic [TB-1:0]                         step;
  logic                                  out_valid;
  logic [TB-1:0]                         out_track;
  logic [TB-1:0]                         out_step;
  logic [SW-1:0]                         out_total;
  logic                                  out_last;

  logic                                  in_fire;
  logic                                  store_en;
  logic                                  rd_issue;
  logic                                  scan_end;
  logic                                  emit_fire;
  logic                                  final_res;
  logic                                  flip;
  logic                                  give_up;
  logic                                  scan_start;
  logic                                  take;
  ldsched_pkg::cmp_in_t                  cmp_op;
  logic [SW:0]                           sum_wide;
  logic [SW-1:0]                         sum_next;

  assign cfg_ready = 1'b1;
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign store_en  = in_fire && (count < MAX_CNT);
  assign scan_end  = ({1'b0, scan_addr} == (count - CW'(1)));
  assign final_res = ((produced + CW'(1)) == count);

  ldsched_store u_store (
    .clk     (clk),
    .wr_en   (store_en),
    .wr_addr (count[IW-1:0]),
    .wr_data (s_axis_tdata),
    .rd_addr (scan_addr),
    .rd_data (rd_data)
  );

  assign cmp_op.cand_open  = rd_valid && !served[rd_idx];
  assign cmp_op.cand       = rd_data;
  assign cmp_op.head       = head;
  assign cmp_op.up         = sweep_up;
  assign cmp_op.best_valid = best_valid;
  assign cmp_op.best_track = best_track;

  ldsched_cmp u_cmp (
    .op   (cmp_op),
    .take (take)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ldsched_pkg::ST_IDLE: begin
        if (in_fire && s_axis_tlast) begin
          state_next = ldsched_pkg::ST_SCAN;
        end
      end
      ldsched_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_next = ldsched_pkg::ST_DRAIN;
        end
      end
      ldsched_pkg::ST_DRAIN: state_next = ldsched_pkg::ST_DECIDE;
      ldsched_pkg::ST_DECIDE: begin
        if (best_valid) begin
          state_next = ldsched_pkg::ST_EMIT;
        end else if (!flipped) begin
          state_next = ldsched_pkg::ST_SCAN;
        end else begin
          state_next = ldsched_pkg::ST_IDLE;
        end
      end
      ldsched_pkg::ST_EMIT: begin
        if (emit_fire) begin
          state_next = final_res ? ldsched_pkg::ST_IDLE : ldsched_pkg::ST_SCAN;
        end
      end
      default: state_next = ldsched_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = (state == ldsched_pkg::ST_IDLE);
    rd_issue      = (state == ldsched_pkg::ST_SCAN);
    emit_fire     = (state == ldsched_pkg::ST_EMIT) && (!out_valid || m_axis_tready);
    flip          = (state == ldsched_pkg::ST_DECIDE) && !best_valid && !flipped;
    give_up       = (state == ldsched_pkg::ST_DECIDE) && !best_valid && flipped;
    scan_start    = (in_fire && s_axis_tlast) || flip || (emit_fire && !final_res);
  end

  always_comb begin
    sum_wide = {1'b0, dist_sum} + (SW+1)'(step);
    sum_next = sum_wide[SW] ? ldsched_pkg::SUM_MAX : sum_wide[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ldsched_pkg::ST_IDLE;
      start_head <= '0;
      count      <= '0;
      produced   <= '0;
      served     <= '0;
      head       <= '0;
      sweep_up   <= 1'b1;
      dist_sum   <= '0;
      flipped    <= 1'b0;
      scan_addr  <= '0;
      rd_valid   <= 1'b0;
      best_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= rd_issue;
      if (cfg_valid && cfg_ready) begin
        start_head <= cfg_data;
      end
      if (store_en) begin
        count <= count + CW'(1);
      end
      if (in_fire && s_axis_tlast) begin
        head     <= start_head;
        sweep_up <= 1'b1;
        dist_sum <= '0;
        produced <= '0;
        flipped  <= 1'b0;
      end
      if (rd_issue) begin
        scan_addr <= scan_addr + IW'(1);
      end
      if (scan_start) begin
        scan_addr  <= '0;
        best_valid <= 1'b0;
      end else if (take) begin
        best_valid <= 1'b1;
      end
      if (flip) begin
        sweep_up <= !sweep_up;
        flipped  <= 1'b1;
      end
      if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (emit_fire) begin
        out_valid        <= 1'b1;
        served[best_idx] <= 1'b1;
        head             <= best_track;
        dist_sum         <= sum_next;
        produced         <= produced + CW'(1);
        flipped          <= 1'b0;
      end
      // batch end clears the stored requests and their marks
      if ((emit_fire && final_res) || give_up) begin
        count  <= '0;
        served <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_idx <= scan_addr;
    if (take) begin
      best_track <= rd_data;
      best_idx   <= rd_idx;
    end
    if (state == ldsched_pkg::ST_DECIDE) begin
      step <= (best_track >= head) ? (best_track - head) : (head - best_track);
    end
    if (emit_fire) begin
      out_track <= best_track;
      out_step  <= step;
      out_total <= sum_next;
      out_last  <= final_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_total, out_step, out_track};
  assign m_axis_tlast  = out_last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_CNT)
    else $error("request count beyond store depth");

  a_idle_marks_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ldsched_pkg::ST_IDLE) |-> (served == '0))
    else $error("served marks left set between batches");

  a_emit_has_pick: assert property (@(posedge clk) disable iff (rst)
    (state == ldsched_pkg::ST_EMIT) |-> best_valid)
    else $error("emit without a chosen request");

  a_emit_marks: assert property (@(posedge clk) disable iff (rst)
    (emit_fire && !final_res) |=> served[$past(best_idx)])
    else $error("serviced request not marked");

endmodule

[sim/tb_top.sv]
// self-checking bench for the look disk scheduler core: batches of track requests
// are streamed in and every serviced track is checked against a local look planner
// depends on ldsched_pkg and look_disk_scheduler_core
`timescale 1ns / 100ps

module tb_top;
  localparam int MAX_REQUESTS = ldsched_pkg::MAX_REQUESTS;
  localparam int TRACK_BITS   = ldsched_pkg::TRACK_BITS;
  localparam int SUM_W        = ldsched_pkg::SUM_W;
  localparam logic [SUM_W-1:0] SUM_MAX = ldsched_pkg::SUM_MAX;

  localparam int RANDOM_ITEMS = 80;
  localparam int CALM_ITEMS   = 30;   // tail of the random part with no idling
  localparam int SETTLE       = 40;   // cycles allowed for the core to go quiet
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 4000;

  typedef struct packed {
    logic [TRACK_BITS-1:0] track;
    logic [TRACK_BITS-1:0] seek;
    logic [SUM_W-1:0]      total;
    logic                  last;
  } service_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;       // start_head
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // request_track
  logic        s_axis_tlast;   // in_last
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;   // served_track, step_distance, total_distance, pad
  logic        m_axis_tlast;   // out_last

  // planner state, mirrors the core
  logic [TRACK_BITS-1:0] track_store [MAX_REQUESTS];
  logic                  served_bit  [MAX_REQUESTS];
  int                    stored_count;
  logic [TRACK_BITS-1:0] head_track;
  logic                  sweep_dir_up;
  logic [SUM_W-1:0]      seek_total;
  logic [TRACK_BITS-1:0] start_track;

  service_t due_services[$];

  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;
  int fault_count;
  int requests_sent;
  int batches_sent;
  int results_seen;
  int cfg_writes;

  look_disk_scheduler_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void log_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  // nearest open request in the current sweep direction, -1 when none
  function automatic int nearest_open();
    int best = -1;
    for (int i = 0; i < stored_count; i++) begin
      if (!served_bit[i]) begin
        if (sweep_dir_up) begin
          if (track_store[i] >= head_track && (best < 0 || track_store[i] < track_store[best]))
            best = i;
        end else begin
          if (track_store[i] <= head_track && (best < 0 || track_store[i] > track_store[best]))
            best = i;
        end
      end
    end
    return best;
  endfunction

  // store one accepted request; on the flagged one plan the whole look order
  function automatic void plan_service(input logic [TRACK_BITS-1:0] trk, input logic lst);
    int               k;
    int               produced;
    logic [TRACK_BITS-1:0] seek_dist;
    logic [SUM_W:0]   wide;
    service_t         svc;
    if (stored_count < MAX_REQUESTS) begin
      track_store[stored_count] = trk;
      served_bit[stored_count]  = 1'b0;
      stored_count++;
    end
    if (!lst) return;
    head_track   = start_track;
    sweep_dir_up = 1'b1;
    seek_total   = '0;
    produced     = 0;
    while (produced < stored_count) begin
      k = nearest_open();
      if (k < 0) begin
        sweep_dir_up = !sweep_dir_up;
        k = nearest_open();
        if (k < 0) break;
      end
      seek_dist = (track_store[k] >= head_track) ? track_store[k] - head_track
                                                 : head_track - track_store[k];
      wide = {1'b0, seek_total} + (SUM_W+1)'(seek_dist);
      seek_total = (wide > SUM_MAX) ? SUM_MAX : wide[SUM_W-1:0];
      head_track = track_store[k];
      served_bit[k] = 1'b1;
      svc.track = track_store[k];
      svc.seek  = seek_dist;
      svc.total = seek_total;
      svc.last  = 1'b0;
      due_services.push_back(svc);
      produced++;
    end
    if (produced > 0) due_services[due_services.size() - 1].last = 1'b1;
    for (int i = 0; i < MAX_REQUESTS; i++) served_bit[i] = 1'b0;
    stored_count = 0;
  endfunction

  task automatic send_request(input logic [TRACK_BITS-1:0] trk, input logic lst);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= trk;
    s_axis_tlast  <= lst;
    do @(posedge clk); while (!s_axis_tready);
    requests_sent++;
    plan_service(trk, lst);
  endtask

  task automatic send_batch(input logic [TRACK_BITS-1:0] tracks[$]);
    foreach (tracks[i]) send_request(tracks[i], i == tracks.size() - 1);
    batches_sent++;
  endtask

  // wait for every planned result, then let the core go quiet
  task automatic await_idle();
    s_axis_tvalid <= 1'b0;
    while (due_services.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_start_head(input logic [15:0] value);
    await_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    start_track = value;
    cfg_writes++;
  endtask

  function automatic logic [TRACK_BITS-1:0] pick_track();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 3))
      0:       pick_track = r[15:0];
      1:       pick_track = start_track + 16'($urandom_range(0, 64)) - 16'd32;
      2:       pick_track = r[0] ? 16'hFFFF : 16'h0000;
      default: pick_track = 16'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [15:0] pick_start();
    case ($urandom_range(0, 3))
      0:       pick_start = 16'h0000;
      1:       pick_start = 16'hFFFF;
      default: pick_start = 16'($urandom);
    endcase
  endfunction

  // head from reset sits at track zero
  task automatic test_single_requests();
    send_batch('{16'h0000});
    send_batch('{16'hFFFF});
  endtask

  task automatic test_equal_tracks();
    write_start_head(16'd100);
    send_batch('{16'd100, 16'd100, 16'd40, 16'd160, 16'd160});
  endtask

  task automatic test_reversal();
    write_start_head(16'd1000);
    send_batch('{16'd1500, 16'd200, 16'd1200, 16'd900, 16'd999});
  endtask

  // head at the top: everything but the top track lies below
  task automatic test_head_at_top();
    write_start_head(16'hFFFF);
    send_batch('{16'd5, 16'd300, 16'hFFFF, 16'h0000});
  endtask

  task automatic test_head_at_bottom();
    write_start_head(16'h0000);
    send_batch('{16'd7, 16'd3, 16'hFFFF});
  endtask

  // requests past a full store are dropped, the flag still ends the batch
  task automatic test_store_full();
    logic [TRACK_BITS-1:0] tracks[$];
    write_start_head(pick_start());
    repeat (MAX_REQUESTS + $urandom_range(1, 4)) tracks.push_back(16'($urandom));
    send_batch(tracks);
  endtask

  // sink holds off while two batches are offered back to back
  task automatic test_receiver_hold_off();
    logic [TRACK_BITS-1:0] tracks[$];
    write_start_head(pick_start());
    hold_req = 1'b1;
    repeat (12) tracks.push_back(pick_track());
    send_batch(tracks);
    tracks.delete();
    repeat (6) tracks.push_back(pick_track());
    send_batch(tracks);
  endtask

  task automatic test_random_batches();
    logic [TRACK_BITS-1:0] tracks[$];
    int len;
    int issued;
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      if (issued >= RANDOM_ITEMS - CALM_ITEMS) idle_on = 1'b0;
      if ($urandom_range(0, 2) == 0) write_start_head(pick_start());
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, MAX_REQUESTS)
                                        : $urandom_range(1, 8);
      tracks.delete();
      repeat (len) tracks.push_back(pick_track());
      send_batch(tracks);
      issued += len;
    end
  endtask

  initial begin : result_sink
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  initial begin : result_check
    service_t got;
    service_t want;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        got.track = m_axis_tdata[TRACK_BITS-1:0];
        got.seek  = m_axis_tdata[2*TRACK_BITS-1:TRACK_BITS];
        got.total = m_axis_tdata[2*TRACK_BITS+SUM_W-1:2*TRACK_BITS];
        got.last  = m_axis_tlast;
        results_seen++;
        if (due_services.size() == 0) begin
          log_fault($sformatf("unexpected result track %0d seek %0d total %0d last %0b",
                              got.track, got.seek, got.total, got.last));
        end else begin
          want = due_services.pop_front();
          if (got !== want)
            log_fault($sformatf({"result mismatch: exp track %0d seek %0d total %0d last %0b,",
                                 " got track %0d seek %0d total %0d last %0b"},
                                want.track, want.seek, want.total, want.last,
                                got.track, got.seek, got.total, got.last));
        end
      end
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        stuck = 0;
      else
        stuck++;
    end
    $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    fault_count   = 0;
    requests_sent = 0;
    batches_sent  = 0;
    results_seen  = 0;
    cfg_writes    = 0;
    stored_count  = 0;
    head_track    = '0;
    sweep_dir_up  = 1'b1;
    seek_total    = '0;
    start_track   = '0;
    for (int i = 0; i < MAX_REQUESTS; i++) served_bit[i] = 1'b0;
    rst           <= 1'b1;
    cfg_valid     <= 1'b0;
    cfg_data      <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_single_requests();
    test_equal_tracks();
    test_reversal();
    test_head_at_top();
    test_head_at_bottom();
    test_store_full();
    test_receiver_hold_off();
    test_random_batches();
    await_idle();

    if (due_services.size() != 0)
      log_fault($sformatf("%0d results never arrived", due_services.size()));
    $display("covered %0d requests in %0d batches, %0d results, %0d start_head writes",
             requests_sent, batches_sent, results_seen, cfg_writes);
    $display("incl. full store drop, head at both ends, reversals and a long sink hold-off");
    if (fault_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

[files.f]
design/ldsched_pkg.sv
design/ldsched_store.sv
design/ldsched_cmp.sv
design/look_disk_scheduler_core.sv
sim/tb_top.sv
